@@ sv/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, byte-class constants and the result word type of the
// UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W    = 8;
  localparam int CP_W      = 21;
  localparam int NARROW_W  = 16;
  localparam int PEND_W    = 2;
  localparam int CONT_BITS = 6;

  // Lead-byte class boundaries
  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;

  // Output skid buffer depth
  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            incomplete;
    logic            end_of_buffer;
  } res_t;

endpackage

@@ sv/utf8d_decode.sv @@
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state (pending count, partial code point) and the single-pass
// decode of one registered byte into zero or one result word.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [utf8d_pkg::BYTE_W-1:0]     byte_in,
  input  logic                             last_byte,
  input  logic                             wide,
  output logic                             res_valid,
  output utf8d_pkg::res_t                  res
);

  logic [utf8d_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [utf8d_pkg::CP_W-1:0]   part_r, part_nxt;
  logic [utf8d_pkg::CP_W-1:0]   cont_sh;
  logic [utf8d_pkg::CP_W-1:0]   merged;
  logic [utf8d_pkg::CP_W-1:0]   cp_raw;
  logic                         produced;
  logic                         inc;

  // Place the continuation's six bits by the count still pending
  always_comb begin
    case (pend_r)
      2'd1:    cont_sh = {{(utf8d_pkg::CP_W-6){1'b0}}, byte_in[5:0]};
      2'd2:    cont_sh = {{(utf8d_pkg::CP_W-12){1'b0}}, byte_in[5:0], 6'b0};
      2'd3:    cont_sh = {{(utf8d_pkg::CP_W-18){1'b0}}, byte_in[5:0], 12'b0};
      default: cont_sh = '0;
    endcase
  end

  assign merged = part_r | cont_sh;

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    produced = 1'b0;
    inc      = 1'b0;
    cp_raw   = '0;
    if (pend_r != '0) begin
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        produced = 1'b1;
        cp_raw   = merged;
        part_nxt = '0;
      end else begin
        part_nxt = merged;
      end
    end else if (byte_in < utf8d_pkg::LEAD2_MIN) begin
      produced = 1'b1;
      cp_raw   = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
    end else if (byte_in < utf8d_pkg::LEAD3_MIN) begin
      part_nxt = {{(utf8d_pkg::CP_W-11){1'b0}}, byte_in[4:0], 6'b0};
      pend_nxt = 2'd1;
    end else if (byte_in < utf8d_pkg::LEAD4_MIN) begin
      part_nxt = {{(utf8d_pkg::CP_W-16){1'b0}}, byte_in[3:0], 12'b0};
      pend_nxt = 2'd2;
    end else begin
      part_nxt = {byte_in[2:0], 18'b0};
      pend_nxt = 2'd3;
    end
    // Buffer end: flush any open sequence as an incomplete word
    if (last_byte) begin
      if (!produced) begin
        produced = 1'b1;
        inc      = 1'b1;
        cp_raw   = part_nxt;
      end
      pend_nxt = '0;
      part_nxt = '0;
    end
  end

  assign res_valid         = produced;
  assign res.incomplete    = inc;
  assign res.end_of_buffer = last_byte;
  assign res.code_point    = wide ? cp_raw :
      {{(utf8d_pkg::CP_W-utf8d_pkg::NARROW_W){1'b0}}, cp_raw[utf8d_pkg::NARROW_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
    end else if (step) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

@@ sv/utf8d_obuf.sv @@
// ----------------------------------------------------------------------------
// utf8d_obuf
// Two-entry result buffer: the output register plus one skid entry, so the
// decode side keeps going while a word waits on a stalled consumer.
// ----------------------------------------------------------------------------
module utf8d_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8d_pkg::res_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output utf8d_pkg::res_t head
);

  utf8d_pkg::res_t ent_r [utf8d_pkg::OBUF_DEPTH];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'(utf8d_pkg::OBUF_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/utf8_byte_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream, one byte per word, into code points.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   in_      | in_valid/in_stall  | in_byte_in[7:0], in_last_byte
//   out_     | out_valid/out_stall| out_code_point[20:0], out_incomplete,
//            |                    | out_end_of_buffer
//   cfg_     | cfg_valid/cfg_ready| cfg_wide_output
//
// Throughput is one byte word per clock while in_stall is low. A byte is
// held in the input register; its result (if any) is written into the
// output buffer when that byte advances, and out_valid comes from there.
// Reset (synchronous, rst_n low) empties both stages, clears the sequence
// state and sets wide output mode. out_stall only backs up into in_stall once
// the two-entry output buffer is full and the registered byte has a result.
//
module utf8_byte_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte_in,
  input  logic                          in_last_byte,
  // code point output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CP_W-1:0]    out_code_point,
  output logic                          out_incomplete,
  output logic                          out_end_of_buffer,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_wide_output
);

  logic                         wide_r;
  logic                         s1_valid_r;
  logic [utf8d_pkg::BYTE_W-1:0] s1_byte_r;
  logic                         s1_last_r;
  logic                         s1_adv;
  logic                         s1_step;
  logic                         res_valid;
  utf8d_pkg::res_t              res;
  logic                         ob_full;
  logic                         ob_pop;
  utf8d_pkg::res_t              ob_head;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      wide_r <= cfg_wide_output;
    end
  end

  // Hold the registered byte only when it has a result and no room to put it
  assign s1_adv   = !(res_valid && ob_full);
  assign s1_step  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload: load on accept, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
  end

  // Decode the registered byte against the sequence state
  utf8d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_step),
    .byte_in   (s1_byte_r),
    .last_byte (s1_last_r),
    .wide      (wide_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign ob_pop = out_valid && !out_stall;

  // Result register with skid entry
  utf8d_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_step && res_valid),
    .push_data  (res),
    .pop        (ob_pop),
    .full       (ob_full),
    .head_valid (out_valid),
    .head       (ob_head)
  );

  assign out_code_point    = ob_head.code_point;
  assign out_incomplete    = ob_head.incomplete;
  assign out_end_of_buffer = ob_head.end_of_buffer;

endmodule

@@ sv/utf8d_checker.sv @@
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [utf8d_pkg::CP_W-1:0] out_code_point,
  input logic                       out_incomplete,
  input logic                       out_end_of_buffer,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       cfg_wide_output
);

  logic wide_r;

  // Track the mode from the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      wide_r <= cfg_wide_output;
    end
  end

  a_inc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_incomplete |-> out_end_of_buffer)
    else $error("incomplete word without end of buffer");

  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !wide_r |-> out_code_point[utf8d_pkg::CP_W-1:utf8d_pkg::NARROW_W] == '0)
    else $error("narrow mode code point exceeds 16 bits");

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result word present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_incomplete) && $stable(out_end_of_buffer))
    else $error("stalled result word changed");

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_utf8d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_code_point    (out_code_point),
  .out_incomplete    (out_incomplete),
  .out_end_of_buffer (out_end_of_buffer),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready),
  .cfg_wide_output   (cfg_wide_output)
);

@@ sim/utf8_byte_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_tb
// Self-checking bench for the UTF-8 byte stream decoder. A short directed
// table covers byte classes, sequence lengths, extremes and buffer ends; then
// random runs of mostly well-formed sequences go through both output widths
// under varied stall patterns. Every result word is checked against an
// in-bench decoder model or, for typed directed rows, a hand-written value.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES   = 6;     // pipeline depth plus margin
  localparam int PHASE_BYTES    = 500;   // random byte words per phase
  localparam int LONG_HOLD      = 80;    // receiver hold-off, in cycles
  localparam int MAX_REPORTS    = 10;

  // One byte word plus, for directed rows, a hand-written expectation.
  typedef struct {
    logic [utf8d_pkg::BYTE_W-1:0] data;
    logic                         last;
    bit                           typed;
    bit                           has_result;
    logic [utf8d_pkg::CP_W-1:0]   cp;
    logic                         inc;
    logic                         eob;
  } byte_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [utf8d_pkg::BYTE_W-1:0] in_byte_in = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [utf8d_pkg::CP_W-1:0] out_code_point;
  logic out_incomplete;
  logic out_end_of_buffer;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_wide_output = 1'b0;

  utf8_byte_stream_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_in        (in_byte_in),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_point    (out_code_point),
    .out_incomplete    (out_incomplete),
    .out_end_of_buffer (out_end_of_buffer),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_wide_output   (cfg_wide_output)
  );

  // 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // Decoder model state: pending continuation count, gathered bits, width mode.
  logic [utf8d_pkg::PEND_W-1:0] seq_pending;
  logic [utf8d_pkg::CP_W-1:0]   seq_partial;
  logic                         wide_mode;

  utf8d_pkg::res_t pending_code_points[$];   // code points owed, oldest first
  byte_word_t dir_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;              // bumped by the main thread to ask for a hold-off
  int fail_count = 0;
  int idle_cycles = 0;

  // Apply the width mode and pack one result word.
  function automatic utf8d_pkg::res_t shape_code_point(
      input logic [utf8d_pkg::CP_W-1:0] cp, input logic inc, input logic eob);
    utf8d_pkg::res_t r;
    r.code_point    = wide_mode ? cp :
        {{(utf8d_pkg::CP_W-utf8d_pkg::NARROW_W){1'b0}}, cp[utf8d_pkg::NARROW_W-1:0]};
    r.incomplete    = inc;
    r.end_of_buffer = eob;
    return r;
  endfunction

  // Advance the model by one byte; returns 1 when a code point comes out.
  function automatic bit decode_byte(input logic [utf8d_pkg::BYTE_W-1:0] b,
                                     input logic last, output utf8d_pkg::res_t r);
    bit produced;
    int sh;
    produced = 1'b0;
    r = '0;
    if (seq_pending != 0) begin
      // continuation: low 6 bits land at their final position, no checking
      sh = utf8d_pkg::CONT_BITS * (int'(seq_pending) - 1);
      seq_partial = seq_partial |
          ({{(utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS){1'b0}},
            b[utf8d_pkg::CONT_BITS-1:0]} << sh);
      seq_pending = seq_pending - 1'b1;
      if (seq_pending == 0) begin
        r = shape_code_point(seq_partial, 1'b0, last);
        seq_partial = '0;
        produced = 1'b1;
      end
    end else if (b < utf8d_pkg::LEAD2_MIN) begin
      // ASCII and stray continuation bytes pass straight through
      r = shape_code_point({{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, b}, 1'b0, last);
      produced = 1'b1;
    end else if (b < utf8d_pkg::LEAD3_MIN) begin
      seq_partial = {10'b0, b[4:0], 6'b0};
      seq_pending = 2'd1;
    end else if (b < utf8d_pkg::LEAD4_MIN) begin
      seq_partial = {5'b0, b[3:0], 12'b0};
      seq_pending = 2'd2;
    end else begin
      seq_partial = {b[2:0], 18'b0};
      seq_pending = 2'd3;
    end
    if (last) begin
      // buffer ends with a sequence still open: flush the partial value
      if (!produced) begin
        r = shape_code_point(seq_partial, 1'b1, 1'b1);
        produced = 1'b1;
      end
      seq_pending = '0;
      seq_partial = '0;
    end
    return produced;
  endfunction

  // Queue a directed row; cp/inc/eob matter only when typed is set.
  task automatic add_row(input logic [utf8d_pkg::BYTE_W-1:0] b, input logic last,
                         input bit typed, input bit has_result,
                         input logic [utf8d_pkg::CP_W-1:0] cp,
                         input logic inc, input logic eob);
    byte_word_t w;
    w.data = b;
    w.last = last;
    w.typed = typed;
    w.has_result = has_result;
    w.cp = cp;
    w.inc = inc;
    w.eob = eob;
    dir_words.push_back(w);
  endtask

  // Offer one byte word, hold it until taken, then log what it should produce.
  task automatic send_word(input byte_word_t w);
    utf8d_pkg::res_t r;
    bit got;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte_in   <= w.data;
    in_last_byte <= w.last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    got = decode_byte(w.data, w.last, r);
    if (w.typed) begin
      // model still advances; the typed value is what gets checked
      if (w.has_result) begin
        pending_code_points.push_back('{code_point: w.cp, incomplete: w.inc,
                                        end_of_buffer: w.eob});
      end
    end else if (got) begin
      pending_code_points.push_back(r);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drain everything, let a buffered lead byte settle, then write the mode.
  task automatic write_width_mode(input logic wide);
    drop_valid();
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_wide_output <= wide;
    do @(posedge clk); while (!cfg_ready);
    wide_mode = wide;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random run: mostly well-formed sequences with random payload bits,
  // some noise bytes, and some sequences cut short.
  task automatic send_random_run(output int n_sent);
    logic [utf8d_pkg::BYTE_W-1:0] seq_bytes[$];
    byte_word_t w;
    int kind;
    int len;
    int keep;
    bit end_buf;
    kind = $urandom_range(0, 99);
    end_buf = ($urandom_range(0, 15) == 0);
    len = 1;
    if (kind < 30) begin
      seq_bytes.push_back(8'($urandom_range(0, 8'h7F)));
    end else if (kind < 85 && kind >= 75) begin
      seq_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = (kind < 45) ? 2 : (kind < 60) ? 3 : (kind < 75) ? 4 : $urandom_range(2, 4);
      case (len)
        2: seq_bytes.push_back(utf8d_pkg::LEAD2_MIN | 8'($urandom_range(0, 31)));
        3: seq_bytes.push_back(utf8d_pkg::LEAD3_MIN | 8'($urandom_range(0, 15)));
        default: seq_bytes.push_back(utf8d_pkg::LEAD4_MIN | 8'($urandom_range(0, 15)));
      endcase
      // cut short: mostly closed by a buffer end, otherwise broken mid-stream
      keep = (kind >= 85) ? $urandom_range(0, len - 2) : len - 1;
      if (kind >= 85) end_buf = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < keep; i++) begin
        seq_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
      end
    end
    foreach (seq_bytes[i]) begin
      w = '{default: '0};
      w.data = seq_bytes[i];
      w.last = end_buf && (i == seq_bytes.size() - 1);
      send_word(w);
    end
    n_sent = seq_bytes.size();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input bit long_hold,
                           input bit mid_pause);
    int sent;
    int n;
    bit paused;
    sent = 0;
    paused = 1'b0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    // hold the receiver off while the sender keeps offering, to back up the input
    if (long_hold) hold_reqs++;
    while (sent < PHASE_BYTES) begin
      if (mid_pause && !paused && sent >= PHASE_BYTES / 2) begin
        drop_valid();
        while (pending_code_points.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      send_random_run(n);
      sent += n;
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    utf8d_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_code_points.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result cp=%h inc=%b eob=%b", $time,
                   out_code_point, out_incomplete, out_end_of_buffer);
        end
      end else begin
        want = pending_code_points.pop_front();
        if (out_code_point !== want.code_point || out_incomplete !== want.incomplete ||
            out_end_of_buffer !== want.end_of_buffer) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected cp=%h inc=%b eob=%b, got cp=%h inc=%b eob=%b",
                     $time, want.code_point, want.incomplete, want.end_of_buffer,
                     out_code_point, out_incomplete, out_end_of_buffer);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time,
                 pending_code_points.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    // synchronous reset, held from the start
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    seq_pending = '0;
    seq_partial = '0;
    wide_mode   = 1'b1;

    // Directed table. Typed rows: byte, last, typed, has_result, cp, inc, eob.
    add_row(8'h00, 1'b0, 1, 1, 21'h000000, 1'b0, 1'b0);  // lowest ASCII
    add_row(8'h7F, 1'b0, 1, 1, 21'h00007F, 1'b0, 1'b0);  // highest ASCII
    add_row(8'h80, 1'b0, 1, 1, 21'h000080, 1'b0, 1'b0);  // stray continuation
    add_row(8'hBF, 1'b0, 1, 1, 21'h0000BF, 1'b0, 1'b0);
    add_row(8'hC3, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // two-byte sequence
    add_row(8'hA9, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hC0, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // overlong zero
    add_row(8'h80, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hE2, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // three-byte sequence
    add_row(8'h82, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hAC, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hF0, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // four-byte sequence
    add_row(8'h9F, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'h98, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1, 0, '0, 1'b0, 1'b0);          // all ones everywhere
    add_row(8'hFF, 1'b0, 1, 0, '0, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1, 0, '0, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1, 1, 21'h1FFFFF, 1'b0, 1'b0);
    add_row(8'h41, 1'b1, 1, 1, 21'h000041, 1'b0, 1'b1);  // buffer ends on ASCII
    add_row(8'hE4, 1'b1, 1, 1, 21'h004000, 1'b1, 1'b1);  // lead byte is the last
    add_row(8'hF4, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // ends one byte into four
    add_row(8'h8F, 1'b1, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hC2, 1'b0, 0, 0, '0, 1'b0, 1'b0);          // completes on the last byte
    add_row(8'hA2, 1'b1, 0, 0, '0, 1'b0, 1'b0);
    add_row(8'hFF, 1'b1, 1, 1, 21'h1C0000, 1'b1, 1'b1);  // top lead, cut at once

    write_width_mode(1'b1);
    foreach (dir_words[i]) send_word(dir_words[i]);

    // Random phases: narrow, wide with a sender pause, narrow at full rate.
    write_width_mode(1'b0);
    run_phase(19, 59, 1'b0, 1'b0);
    write_width_mode(1'b1);
    run_phase(59, 19, 1'b0, 1'b1);
    write_width_mode(1'b0);
    run_phase(0, 0, 1'b1, 1'b0);

    // Drain, then give the pipeline time to show any stray word.
    drop_valid();
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_code_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ utf8_byte_stream_decoder.f @@
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8d_obuf.sv
sv/utf8_byte_stream_decoder.sv
sv/utf8d_checker.sv
sim/utf8_byte_stream_decoder_tb.sv
